>>> rtl/nlps_pkg.sv
`default_nettype none

package nlps_pkg;

    localparam int ByteWidth     = 8;
    localparam int PrefixWidth   = 3;
    localparam int LengthWidth   = 32;
    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 8;

    localparam logic [CfgIndexWidth-1:0] RegLengthPrefixedMode = CfgIndexWidth'(0);
    localparam logic [CfgIndexWidth-1:0] RegPrefixBytes        = CfgIndexWidth'(1);

    localparam logic [PrefixWidth-1:0] PrefixMin = PrefixWidth'(1);
    localparam logic [PrefixWidth-1:0] PrefixMax = PrefixWidth'(4);

    typedef struct packed {
        logic                   length_prefixed_mode;
        logic [PrefixWidth-1:0] prefix_bytes;
    } t_cfg;

    function automatic logic [PrefixWidth-1:0] effective_prefix(
        input logic [PrefixWidth-1:0] size
    );
        logic [PrefixWidth-1:0] eff;
        eff = size;
        if (size == '0) begin
            eff = PrefixMin;
        end else if (size > PrefixMax) begin
            eff = PrefixMax;
        end
        return eff;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nal_length_prefix_stripper_top.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------
// in       | sink      | i_in_valid / o_in_stall | i_data_byte, i_packet_end
// out      | source    | o_out_valid / i_out_stall | o_hash_byte
// cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle unless stalled; a forwarded byte shows in the cycle after its transfer.
// The parser state updates in the cycle of the transfer; the output register sets the latency.
// Synchronous active-low reset clears the parser state and output valid; cfg goes to defaults.
// The input stalls only while the output register is full and the output is stalled.
`default_nettype none

module nal_length_prefix_stripper_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [nlps_pkg::ByteWidth-1:0]      i_data_byte,
    input  wire                                 i_packet_end,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [nlps_pkg::ByteWidth-1:0]      o_hash_byte,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [nlps_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  wire  [nlps_pkg::CfgDataWidth-1:0]   i_cfg_data
);
    import nlps_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_out_valid;
    logic [ByteWidth-1:0] r_out_byte;
    logic                 in_accept;
    logic                 emit;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_hash_byte = r_out_byte;

    nlps_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_packet_end (i_packet_end),
        .o_emit       (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length_prefixed_mode <= 1'b0;
            r_cfg.prefix_bytes         <= PrefixMax;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == RegLengthPrefixedMode) begin
                r_cfg.length_prefixed_mode <= i_cfg_data[0];
            end else if (i_cfg_index == RegPrefixBytes) begin
                r_cfg.prefix_bytes <= i_cfg_data[PrefixWidth-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the byte while stalled, load on a forwarded transfer
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= i_data_byte;
        end
    end

    a_passthrough_forwards: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !r_cfg.length_prefixed_mode |=>
            o_out_valid && o_hash_byte == $past(i_data_byte))
        else $error("pass-through byte not forwarded");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !emit)
        else $error("pending output overwritten");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> rtl/nlps_parser.sv
`default_nettype none

module nlps_parser (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  nlps_pkg::t_cfg              i_cfg,
    input  wire                         i_accept,
    input  wire [nlps_pkg::ByteWidth-1:0] i_data_byte,
    input  wire                         i_packet_end,
    output logic                        o_emit
);
    import nlps_pkg::*;

    logic                   r_in_payload;
    logic                   n_in_payload;
    logic [PrefixWidth-1:0] r_prefix_count;
    logic [PrefixWidth-1:0] n_prefix_count;
    logic [LengthWidth-1:0] r_length;
    logic [LengthWidth-1:0] n_length;
    logic [PrefixWidth-1:0] cnt_inc;

    always_comb begin
        n_in_payload   = r_in_payload;
        n_prefix_count = r_prefix_count;
        n_length       = r_length;
        o_emit         = 1'b0;
        cnt_inc        = r_prefix_count + PrefixWidth'(1);
        if (i_accept) begin
            if (!i_cfg.length_prefixed_mode) begin
                o_emit = 1'b1;
            end else if (r_in_payload) begin
                o_emit   = 1'b1;
                n_length = r_length - LengthWidth'(1);
                if (n_length == '0) begin
                    n_in_payload = 1'b0;
                end
            end else begin
                if (r_prefix_count == '0) begin
                    n_length = {{(LengthWidth-ByteWidth){1'b0}}, i_data_byte};
                end else begin
                    n_length = {r_length[LengthWidth-ByteWidth-1:0], i_data_byte};
                end
                if (cnt_inc >= effective_prefix(i_cfg.prefix_bytes)) begin
                    n_prefix_count = '0;
                    if (n_length != '0) begin
                        n_in_payload = 1'b1;
                    end
                end else begin
                    n_prefix_count = cnt_inc;
                end
            end
            if (i_packet_end) begin
                n_in_payload   = 1'b0;
                n_prefix_count = '0;
                n_length       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload   <= 1'b0;
            r_prefix_count <= '0;
            r_length       <= '0;
        end else begin
            r_in_payload   <= n_in_payload;
            r_prefix_count <= n_prefix_count;
            r_length       <= n_length;
        end
    end

    a_count_only_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix_count != '0 |-> !r_in_payload)
        else $error("prefix count nonzero while in payload");

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_length != '0)
        else $error("in payload with zero bytes remaining");

    a_packet_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_packet_end |=>
            !r_in_payload && r_prefix_count == '0 && r_length == '0)
        else $error("state not cleared after packet end");

endmodule

`default_nettype wire

>>> test/tb_nal_length_prefix_stripper_top.sv
`timescale 1ns / 1ps

module tb_nal_length_prefix_stripper_top;

    import nlps_pkg::*;

    localparam int TotalItems  = 720;
    localparam int IdleLimit   = 3000;
    localparam int HoldCycles  = 300;
    localparam int SettleCycles = 4;
    localparam int MaxPrinted  = 50;

    localparam logic [CfgIndexWidth-1:0] FirstUnusedReg = RegPrefixBytes + 1'b1;
    localparam logic [CfgDataWidth-1:0]  ModePassThrough = 8'h00;
    localparam logic [CfgDataWidth-1:0]  ModeStrip       = 8'h01;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [ByteWidth-1:0]     i_data_byte = '0;
    logic                     i_packet_end = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [ByteWidth-1:0]     o_hash_byte;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [CfgDataWidth-1:0]  i_cfg_data = '0;

    nal_length_prefix_stripper_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_packet_end (i_packet_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_byte  (o_hash_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Parser copy kept by the bench
    logic                   strip_mode      = 1'b0;
    logic [PrefixWidth-1:0] prefix_size_reg = PrefixWidth'(4);
    logic                   in_payload      = 1'b0;
    logic [PrefixWidth-1:0] prefix_seen     = '0;
    logic [LengthWidth-1:0] unit_left       = '0;

    logic [ByteWidth-1:0] expected_hash[$];
    int err_count   = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int pattern_left = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    function automatic logic [PrefixWidth-1:0] unit_prefix_len(input logic [PrefixWidth-1:0] s);
        logic [PrefixWidth-1:0] n;
        case (s)
            3'd0: n = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4: n = s;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic predict_hash(input logic [ByteWidth-1:0] b, input logic last);
        logic fwd;
        fwd = 1'b0;
        if (!strip_mode) begin
            fwd = 1'b1;
        end else if (in_payload) begin
            fwd = 1'b1;
            unit_left = unit_left - 1'b1;
            if (unit_left == '0) begin
                in_payload = 1'b0;
            end
        end else begin
            unit_left = (prefix_seen == '0) ? LengthWidth'(b) : {unit_left[LengthWidth-9:0], b};
            prefix_seen = prefix_seen + 1'b1;
            if (prefix_seen >= unit_prefix_len(prefix_size_reg)) begin
                prefix_seen = '0;
                if (unit_left != '0) begin
                    in_payload = 1'b1;
                end
            end
        end
        if (last) begin
            in_payload  = 1'b0;
            prefix_seen = '0;
            unit_left   = '0;
        end
        return fwd;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MaxPrinted) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last);
        int gap;
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_packet_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_hash(b, last)) begin
            expected_hash.push_back(b);
        end
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_hash.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == RegLengthPrefixedMode) begin
            strip_mode = val[0];
        end else if (idx == RegPrefixBytes) begin
            prefix_size_reg = val[PrefixWidth-1:0];
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_bytes(input logic [ByteWidth-1:0] seq[$], input logic end_packet);
        foreach (seq[i]) begin
            send_byte(seq[i], end_packet && (i == seq.size() - 1));
        end
    endtask

    task automatic send_noise_packet();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            send_byte(ByteWidth'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic send_unit_packet();
        int units;
        int eff;
        int pl;
        logic [LengthWidth-1:0] declared;
        logic last_unit;
        units = $urandom_range(1, 3);
        eff = int'(unit_prefix_len(prefix_size_reg));
        for (int u = 0; u < units; u++) begin
            last_unit = (u == units - 1);
            if (last_unit && eff > 1 && $urandom_range(0, 7) == 0) begin
                pl = $urandom_range(1, eff - 1);
                for (int i = 0; i < pl; i++) begin
                    send_byte(ByteWidth'($urandom_range(0, 255)), i == pl - 1);
                end
                return;
            end
            case ($urandom_range(0, 9))
                0: declared = '0;
                1: declared = last_unit ? LengthWidth'($urandom()) : LengthWidth'(1);
                default: declared = $urandom_range(1, 12);
            endcase
            declared &= 32'hFFFF_FFFF >> (8 * (4 - eff));
            if (declared == '0) begin
                pl = 0;
            end else if (declared > 12 || (last_unit && $urandom_range(0, 5) == 0)) begin
                pl = $urandom_range(1, 6);
            end else begin
                pl = declared;
            end
            for (int i = 0; i < eff; i++) begin
                send_byte(declared[8 * (eff - 1 - i) +: 8], last_unit && pl == 0 && i == eff - 1);
            end
            for (int i = 0; i < pl; i++) begin
                send_byte(ByteWidth'($urandom_range(0, 255)), last_unit && i == pl - 1);
            end
        end
    endtask

    task automatic test_passthrough_after_reset();
        gap_max = 2;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_idle();
        cfg_write(FirstUnusedReg, 8'hFF);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_prefix_sizes();
        wait_idle();
        cfg_write(RegLengthPrefixedMode, 8'hFF);
        send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC3}, 1'b1);
        wait_idle();
        cfg_write(RegPrefixBytes, 8'hF9);
        send_bytes('{8'h02, 8'hAA, 8'h55, 8'h00, 8'h01, 8'hFF}, 1'b1);
        wait_idle();
        cfg_write(RegPrefixBytes, 8'd2);
        send_bytes('{8'h00, 8'h05, 8'h11, 8'h22}, 1'b1);
    endtask

    task automatic test_prefix_edges();
        wait_idle();
        cfg_write(RegPrefixBytes, 8'd3);
        send_byte(8'h01, 1'b1);
        wait_idle();
        cfg_write(RegPrefixBytes, 8'd0);
        send_bytes('{8'h01, 8'h3C}, 1'b1);
        wait_idle();
        cfg_write(RegPrefixBytes, 8'h07);
        send_bytes('{8'h00, 8'h00}, 1'b0);
        wait_idle();
        cfg_write(RegPrefixBytes, 8'd2);
        send_bytes('{8'h01, 8'h81}, 1'b1);
    endtask

    task automatic test_output_holdoff();
        wait_idle();
        cfg_write(RegLengthPrefixedMode, ModeStrip);
        cfg_write(RegPrefixBytes, 8'd1);
        gap_max = 0;
        hold_reqs <= hold_reqs + 1;
        send_byte(8'd24, 1'b0);
        for (int i = 0; i < 24; i++) begin
            send_byte(ByteWidth'($urandom_range(0, 255)), i == 23);
        end
        wait_idle();
    endtask

    task automatic test_random_packets();
        logic [CfgDataWidth-1:0] mode_data;
        logic [CfgDataWidth-1:0] size_data;
        int phase_end;
        while (items_sent < TotalItems) begin
            wait_idle();
            mode_data = CfgDataWidth'($urandom_range(0, 255));
            mode_data[0] = ($urandom_range(0, 4) != 0) ? ModeStrip[0] : ModePassThrough[0];
            size_data = CfgDataWidth'($urandom_range(0, 255));
            case ($urandom_range(0, 5))
                0: size_data[2:0] = 3'd0;
                1: size_data[2:0] = 3'($urandom_range(5, 7));
                default: size_data[2:0] = 3'($urandom_range(1, 4));
            endcase
            cfg_write(RegLengthPrefixedMode, mode_data);
            cfg_write(RegPrefixBytes, size_data);
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CfgIndexWidth'($urandom_range(FirstUnusedReg, 255)),
                          CfgDataWidth'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase
            phase_end = items_sent + $urandom_range(40, 100);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_noise_packet();
                end else begin
                    send_unit_packet();
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(ByteWidth'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HoldCycles;
        end
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        pattern_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_hash.size() == 0) begin
                report_mismatch($sformatf("unexpected hash byte %02h", o_hash_byte));
            end else begin
                if (o_hash_byte !== expected_hash[0]) begin
                    report_mismatch($sformatf("hash byte %02h, want %02h",
                                              o_hash_byte, expected_hash[0]));
                end
                void'(expected_hash.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_passthrough_after_reset();
        test_prefix_sizes();
        test_prefix_edges();
        test_output_holdoff();
        test_random_packets();
        wait_idle();
        if (expected_hash.size() != 0) begin
            report_mismatch("hash bytes still pending at end of run");
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
